>>> rtl/srtf_pkg.sv
`default_nettype none

package srtf_pkg;

    // sizing
    localparam int MAX_PROC = 16;
    localparam int TIME_W   = 16;
    localparam int SLOT_W   = $clog2(MAX_PROC);
    localparam int CNT_W    = $clog2(MAX_PROC + 1);
    localparam int PNUM_W   = 5;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_TICK = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_LOAD_OK   = 2'd0,
        KIND_LOAD_FULL = 2'd1,
        KIND_RAN       = 2'd2,
        KIND_IDLE      = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } t_state;

    // input transaction
    typedef struct packed {
        t_cmd              command;
        logic [TIME_W-1:0] arrival_time;
        logic [TIME_W-1:0] burst_time;
    } t_in_item;

    // result transaction
    typedef struct packed {
        t_kind             kind;
        logic [PNUM_W-1:0] process_number;
        logic [TIME_W-1:0] slot_start;
        logic              finished;
        logic [TIME_W-1:0] completion_time;
        logic [TIME_W-1:0] turnaround_time;
        logic [TIME_W-1:0] waiting_time;
        logic [TIME_W-1:0] response_time;
        logic              all_done;
    } t_result;

    // one process table entry as held in the ram
    typedef struct packed {
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
        logic [TIME_W-1:0] remaining;
        logic [TIME_W-1:0] first_run;
    } t_entry;

    // selector control from the sequencer
    typedef struct packed {
        logic              clr;
        logic              vld;
        logic [SLOT_W-1:0] idx;
    } t_sel_ctl;

    // best candidate found so far
    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] idx;
        t_entry            entry;
    } t_best;

    // difference clamped at zero
    function automatic logic [TIME_W-1:0] sub_clamp(input logic [TIME_W-1:0] a,
                                                    input logic [TIME_W-1:0] b);
        return (a > b) ? (a - b) : '0;
    endfunction

endpackage

`default_nettype wire

>>> rtl/srtf_ram.sv
`default_nettype none

module srtf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/srtf_sel.sv
`default_nettype none

module srtf_sel (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire srtf_pkg::t_sel_ctl            i_ctl,
    input  wire srtf_pkg::t_entry              i_entry,
    input  wire logic [srtf_pkg::TIME_W-1:0]   i_now,
    output srtf_pkg::t_best                    o_best
);

    logic                      r_found;
    logic [srtf_pkg::SLOT_W-1:0] r_idx;
    srtf_pkg::t_entry          r_entry;
    logic                      ready;
    logic                      take;

    // ready means arrived and unfinished; equal remaining goes to the earlier arrival, then keeps the earlier slot
    always_comb begin
        ready = (i_entry.arrival <= i_now) && (i_entry.remaining != '0);
        take  = i_ctl.vld && ready &&
                (!r_found ||
                 (i_entry.remaining < r_entry.remaining) ||
                 ((i_entry.remaining == r_entry.remaining) &&
                  (i_entry.arrival < r_entry.arrival)));
    end

    // found flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clr) begin
            r_found <= 1'b0;
        end else if (take) begin
            r_found <= 1'b1;
        end
    end

    // best entry payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_idx   <= i_ctl.idx;
            r_entry <= i_entry;
        end
    end

    assign o_best.found = r_found;
    assign o_best.idx   = r_idx;
    assign o_best.entry = r_entry;

endmodule

`default_nettype wire

>>> rtl/shortest_remaining_time_scheduler.sv
// a load returns its result strobe in the cycle after start, busy stays low
// a tick runs from start through a scan of the N loaded processes, then an update;
// the process ram is read one entry per cycle and the winner is written back once
// next transaction may start in the cycle the strobe is shown; receiver cannot stall
// synchronous active-low reset empties the table and clears time and counts
`default_nettype none

module shortest_remaining_time_scheduler (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire srtf_pkg::t_in_item i_item,
    output logic                    busy,
    output logic                    o_strobe,
    output srtf_pkg::t_result       o_result
);

    localparam int ENTRY_W = $bits(srtf_pkg::t_entry);

    srtf_pkg::t_state               r_state, n_state;
    logic [srtf_pkg::CNT_W-1:0]     r_loaded, n_loaded;
    logic [srtf_pkg::CNT_W-1:0]     r_finished, n_finished;
    logic [srtf_pkg::TIME_W-1:0]    r_time, n_time;
    logic [srtf_pkg::MAX_PROC-1:0]  r_started, n_started;
    logic [srtf_pkg::CNT_W-1:0]     r_idx, n_idx;
    logic                           r_vld, n_vld;
    logic [srtf_pkg::SLOT_W-1:0]    r_didx;
    logic [srtf_pkg::TIME_W-1:0]    r_now;
    logic                           r_strobe, n_strobe;
    srtf_pkg::t_result              r_result, n_result;

    logic                           accept;
    logic                           acc_load;
    logic                           acc_tick;
    logic                           full;
    logic                           rd_en;
    logic                           we;
    logic [srtf_pkg::SLOT_W-1:0]    waddr;
    srtf_pkg::t_entry               wdata;
    srtf_pkg::t_entry               rdata;
    logic [ENTRY_W-1:0]             rdata_raw;
    srtf_pkg::t_sel_ctl             sel_ctl;
    srtf_pkg::t_best                best;

    logic [srtf_pkg::TIME_W-1:0]    ld_burst;
    logic [srtf_pkg::TIME_W-1:0]    rem_dec;
    logic [srtf_pkg::TIME_W-1:0]    first_run;
    logic [srtf_pkg::TIME_W-1:0]    ct;
    logic [srtf_pkg::TIME_W-1:0]    tat;
    logic                           fin;

    assign accept   = start && !busy;
    assign acc_load = accept && (i_item.command == srtf_pkg::CMD_LOAD);
    assign acc_tick = accept && (i_item.command == srtf_pkg::CMD_TICK);
    assign full     = (r_loaded == srtf_pkg::CNT_W'(srtf_pkg::MAX_PROC));

    // process table
    srtf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (srtf_pkg::MAX_PROC)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (rd_en),
        .i_raddr (r_idx[srtf_pkg::SLOT_W-1:0]),
        .o_rdata (rdata_raw)
    );

    assign rdata = srtf_pkg::t_entry'(rdata_raw);

    // running minimum over the scanned entries
    srtf_sel u_sel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (sel_ctl),
        .i_entry (rdata),
        .i_now   (r_now),
        .o_best  (best)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            srtf_pkg::ST_IDLE: begin
                if (acc_tick) begin
                    n_state = srtf_pkg::ST_SCAN;
                end
            end
            srtf_pkg::ST_SCAN: begin
                if (r_idx == r_loaded) begin
                    n_state = srtf_pkg::ST_UPDATE;
                end
            end
            srtf_pkg::ST_UPDATE: begin
                n_state = srtf_pkg::ST_IDLE;
            end
            default: begin
                n_state = srtf_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        busy        = 1'b1;
        rd_en       = 1'b0;
        sel_ctl.clr = 1'b0;
        sel_ctl.vld = 1'b0;
        sel_ctl.idx = r_didx;
        case (r_state)
            srtf_pkg::ST_IDLE: begin
                busy        = 1'b0;
                sel_ctl.clr = acc_tick;
            end
            srtf_pkg::ST_SCAN: begin
                rd_en       = (r_idx != r_loaded);
                sel_ctl.vld = r_vld;
            end
            srtf_pkg::ST_UPDATE: begin
                busy = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    // update arithmetic for the chosen process
    always_comb begin
        ld_burst  = (i_item.burst_time == '0) ? srtf_pkg::TIME_W'(1) : i_item.burst_time;
        rem_dec   = best.entry.remaining - srtf_pkg::TIME_W'(1);
        first_run = r_started[best.idx] ? best.entry.first_run : r_now;
        ct        = (r_now == srtf_pkg::TIME_MAX) ? r_now : (r_now + srtf_pkg::TIME_W'(1));
        tat       = srtf_pkg::sub_clamp(ct, best.entry.arrival);
        fin       = (rem_dec == '0);
    end

    // datapath next values and ram writes
    always_comb begin
        n_loaded   = r_loaded;
        n_finished = r_finished;
        n_time     = r_time;
        n_started  = r_started;
        n_idx      = r_idx;
        n_vld      = 1'b0;
        n_strobe   = 1'b0;
        n_result   = r_result;
        we         = 1'b0;
        waddr      = r_loaded[srtf_pkg::SLOT_W-1:0];
        wdata.arrival   = i_item.arrival_time;
        wdata.burst     = ld_burst;
        wdata.remaining = ld_burst;
        wdata.first_run = '0;

        case (r_state)
            srtf_pkg::ST_IDLE: begin
                n_idx = '0;
                // load transaction completes here
                if (acc_load) begin
                    n_strobe                 = 1'b1;
                    n_result                 = '0;
                    n_result.slot_start      = r_time;
                    if (full) begin
                        n_result.kind     = srtf_pkg::KIND_LOAD_FULL;
                        n_result.all_done = (r_finished == r_loaded);
                    end else begin
                        we                       = 1'b1;
                        n_started[r_loaded[srtf_pkg::SLOT_W-1:0]] = 1'b0;
                        n_loaded                 = r_loaded + srtf_pkg::CNT_W'(1);
                        n_result.kind            = srtf_pkg::KIND_LOAD_OK;
                        n_result.process_number  = srtf_pkg::PNUM_W'(n_loaded);
                        n_result.all_done        = (r_finished == n_loaded);
                    end
                end
            end
            srtf_pkg::ST_SCAN: begin
                // one entry read per cycle
                n_vld = rd_en;
                if (rd_en) begin
                    n_idx = r_idx + srtf_pkg::CNT_W'(1);
                end
            end
            srtf_pkg::ST_UPDATE: begin
                n_time              = ct;
                n_strobe            = 1'b1;
                n_result            = '0;
                n_result.slot_start = r_now;
                if (best.found) begin
                    we                      = 1'b1;
                    waddr                   = best.idx;
                    wdata.arrival           = best.entry.arrival;
                    wdata.burst             = best.entry.burst;
                    wdata.remaining         = rem_dec;
                    wdata.first_run         = first_run;
                    n_started[best.idx]     = 1'b1;
                    n_result.kind           = srtf_pkg::KIND_RAN;
                    n_result.process_number = srtf_pkg::PNUM_W'(best.idx) +
                                              srtf_pkg::PNUM_W'(1);
                    if (fin) begin
                        n_finished               = r_finished + srtf_pkg::CNT_W'(1);
                        n_result.finished        = 1'b1;
                        n_result.completion_time = ct;
                        n_result.turnaround_time = tat;
                        n_result.waiting_time    = srtf_pkg::sub_clamp(tat, best.entry.burst);
                        n_result.response_time   = srtf_pkg::sub_clamp(first_run,
                                                                       best.entry.arrival);
                    end
                end else begin
                    n_result.kind = srtf_pkg::KIND_IDLE;
                end
                n_result.all_done = (n_finished == r_loaded);
            end
            default: begin
                n_vld = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= srtf_pkg::ST_IDLE;
            r_loaded   <= '0;
            r_finished <= '0;
            r_time     <= '0;
            r_started  <= '0;
            r_idx      <= '0;
            r_vld      <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_loaded   <= n_loaded;
            r_finished <= n_finished;
            r_time     <= n_time;
            r_started  <= n_started;
            r_idx      <= n_idx;
            r_vld      <= n_vld;
            r_strobe   <= n_strobe;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        r_didx   <= r_idx[srtf_pkg::SLOT_W-1:0];
        if (acc_tick) begin
            r_now <= r_time;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

`default_nettype wire

>>> rtl/srtf_checker.sv
`default_nettype none

module srtf_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               start,
    input wire srtf_pkg::t_in_item i_item,
    input wire logic               busy,
    input wire logic               o_strobe,
    input wire srtf_pkg::t_result  o_result
);

    // a load transaction reports on the next cycle
    a_load_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.command == srtf_pkg::CMD_LOAD)) |=> o_strobe)
        else $error("load transaction without result");

    // a tick transaction makes the block busy
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.command == srtf_pkg::CMD_TICK)) |=> busy)
        else $error("tick transaction did not start a scan");

    // busy only rises from an accepted transaction
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a transaction");

    // a result is shown only when the block is free again
    a_strobe_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result shown while still busy");

    // only a run can finish a process
    a_finish_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.finished) |-> (o_result.kind == srtf_pkg::KIND_RAN))
        else $error("finish reported on a non-run result");

endmodule

bind shortest_remaining_time_scheduler srtf_checker u_srtf_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .i_item   (i_item),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

`default_nettype wire

>>> verif/tb_top.sv
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    // leave room in the table so the full table test still has loads to take
    localparam int RANDOM_LOAD_CAP = 9;
    localparam int RANDOM_ITEMS    = 1200;
    localparam int FINAL_TICKS     = 300;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start   = 1'b0;
    srtf_pkg::t_in_item i_item  = '0;
    logic               busy;
    logic               o_strobe;
    srtf_pkg::t_result  o_result;

    // scheduler state as predicted by the testbench
    logic [srtf_pkg::TIME_W-1:0]   proc_arrival   [srtf_pkg::MAX_PROC];
    logic [srtf_pkg::TIME_W-1:0]   proc_burst     [srtf_pkg::MAX_PROC];
    logic [srtf_pkg::TIME_W-1:0]   proc_remaining [srtf_pkg::MAX_PROC];
    logic [srtf_pkg::TIME_W-1:0]   proc_first_run [srtf_pkg::MAX_PROC];
    logic [srtf_pkg::MAX_PROC-1:0] started_mask   = '0;
    int unsigned                   loaded_cnt     = 0;
    int unsigned                   done_cnt       = 0;
    logic [srtf_pkg::TIME_W-1:0]   sched_now      = '0;

    srtf_pkg::t_result pending_results[$];
    srtf_pkg::t_result want;
    bit          gaps_on    = 1'b1;
    int unsigned error_cnt  = 0;
    int unsigned seen_loads = 0;
    int unsigned seen_full  = 0;
    int unsigned seen_runs  = 0;
    int unsigned seen_done  = 0;
    int unsigned seen_idle  = 0;
    int unsigned drain_wait;

    shortest_remaining_time_scheduler u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always #4 i_clk = ~i_clk;

    // apply one transaction to the predicted state and return its outcome
    function automatic srtf_pkg::t_result schedule_item(input srtf_pkg::t_in_item item);
        srtf_pkg::t_result           res;
        logic [srtf_pkg::TIME_W-1:0] now;
        logic [srtf_pkg::TIME_W-1:0] bst;
        logic [srtf_pkg::TIME_W-1:0] tat;
        int unsigned                 best;
        bit                          found;
        res   = '0;
        now   = sched_now;
        best  = 0;
        found = 1'b0;
        res.slot_start = now;
        if (item.command == srtf_pkg::CMD_LOAD) begin
            if (loaded_cnt >= srtf_pkg::MAX_PROC) begin
                res.kind = srtf_pkg::KIND_LOAD_FULL;
            end else begin
                bst = (item.burst_time == '0) ? srtf_pkg::TIME_W'(1) : item.burst_time;
                proc_arrival[loaded_cnt]   = item.arrival_time;
                proc_burst[loaded_cnt]     = bst;
                proc_remaining[loaded_cnt] = bst;
                proc_first_run[loaded_cnt] = '0;
                started_mask[loaded_cnt]   = 1'b0;
                loaded_cnt++;
                res.kind           = srtf_pkg::KIND_LOAD_OK;
                res.process_number = srtf_pkg::PNUM_W'(loaded_cnt);
            end
        end else begin
            // least remaining, then earliest arrival, then lowest number
            for (int i = 0; i < loaded_cnt; i++) begin
                if (proc_arrival[i] > now || proc_remaining[i] == '0)
                    continue;
                if (!found || proc_remaining[i] < proc_remaining[best] ||
                    (proc_remaining[i] == proc_remaining[best] &&
                     proc_arrival[i] < proc_arrival[best])) begin
                    best  = i;
                    found = 1'b1;
                end
            end
            if (sched_now != srtf_pkg::TIME_MAX)
                sched_now = sched_now + 1'b1;
            if (!found) begin
                res.kind = srtf_pkg::KIND_IDLE;
            end else begin
                if (!started_mask[best]) begin
                    started_mask[best]   = 1'b1;
                    proc_first_run[best] = now;
                end
                proc_remaining[best] = proc_remaining[best] - 1'b1;
                res.kind             = srtf_pkg::KIND_RAN;
                res.process_number   = srtf_pkg::PNUM_W'(best + 1);
                if (proc_remaining[best] == '0) begin
                    done_cnt++;
                    tat = (sched_now > proc_arrival[best]) ? sched_now - proc_arrival[best] : '0;
                    res.finished        = 1'b1;
                    res.completion_time = sched_now;
                    res.turnaround_time = tat;
                    res.waiting_time    = (tat > proc_burst[best]) ? tat - proc_burst[best] : '0;
                    res.response_time   = (proc_first_run[best] > proc_arrival[best]) ?
                                          proc_first_run[best] - proc_arrival[best] : '0;
                end
            end
        end
        res.all_done = (done_cnt == loaded_cnt);
        return res;
    endfunction

    // drive one transaction, wait for it to be taken, record its outcome
    task automatic send_item(input srtf_pkg::t_cmd cmd, input int unsigned arr,
                             input int unsigned bst);
        srtf_pkg::t_in_item item;
        item.command      = cmd;
        item.arrival_time = arr[srtf_pkg::TIME_W-1:0];
        item.burst_time   = bst[srtf_pkg::TIME_W-1:0];
        if (gaps_on && $urandom_range(0, 99) < 20) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= item;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results.push_back(schedule_item(item));
        @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [srtf_pkg::TIME_W-1:0] exp_val,
                               input logic [srtf_pkg::TIME_W-1:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
            error_cnt++;
        end
    endtask

    // compare every result transaction with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with nothing pending: kind %0d process %0d",
                       o_result.kind, o_result.process_number);
                error_cnt++;
            end else begin
                want = pending_results.pop_front();
                check_field("kind", srtf_pkg::TIME_W'(want.kind),
                            srtf_pkg::TIME_W'(o_result.kind));
                check_field("process_number", srtf_pkg::TIME_W'(want.process_number),
                            srtf_pkg::TIME_W'(o_result.process_number));
                check_field("slot_start", want.slot_start, o_result.slot_start);
                check_field("finished", srtf_pkg::TIME_W'(want.finished),
                            srtf_pkg::TIME_W'(o_result.finished));
                check_field("completion_time", want.completion_time, o_result.completion_time);
                check_field("turnaround_time", want.turnaround_time, o_result.turnaround_time);
                check_field("waiting_time", want.waiting_time, o_result.waiting_time);
                check_field("response_time", want.response_time, o_result.response_time);
                check_field("all_done", srtf_pkg::TIME_W'(want.all_done),
                            srtf_pkg::TIME_W'(o_result.all_done));
                case (want.kind)
                    srtf_pkg::KIND_LOAD_OK:   seen_loads++;
                    srtf_pkg::KIND_LOAD_FULL: seen_full++;
                    srtf_pkg::KIND_RAN: begin
                        seen_runs++;
                        if (want.finished)
                            seen_done++;
                    end
                    default:                  seen_idle++;
                endcase
            end
        end
    end

    // ticks with nothing loaded are idle and report all done
    task automatic test_empty_table();
        send_item(srtf_pkg::CMD_TICK, 16'hFFFF, 0);
        send_item(srtf_pkg::CMD_TICK, 0, 16'hFFFF);
    endtask

    // zero burst, equal remaining time split by arrival and by number, tick after all done
    task automatic test_directed_priorities();
        send_item(srtf_pkg::CMD_LOAD, 0, 3);
        send_item(srtf_pkg::CMD_LOAD, 0, 3);
        send_item(srtf_pkg::CMD_LOAD, 1, 0);
        send_item(srtf_pkg::CMD_LOAD, 2, 2);
        send_item(srtf_pkg::CMD_LOAD, 0, 2);
        repeat (12) send_item(srtf_pkg::CMD_TICK, $urandom, $urandom);
    endtask

    // mostly ticks with random payload, loads spread through the run
    task automatic test_random_mix();
        int unsigned arr;
        int unsigned bst;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            gaps_on = !(n >= 600 && n < 900);
            if (loaded_cnt < RANDOM_LOAD_CAP && $urandom_range(0, 149) == 0) begin
                if ($urandom_range(0, 3) == 0)
                    arr = $urandom_range(0, 16'hFFFF);
                else
                    arr = int'(sched_now) + $urandom_range(0, 400);
                if (arr > srtf_pkg::TIME_MAX)
                    arr = srtf_pkg::TIME_MAX;
                if ($urandom_range(0, 3) == 0)
                    bst = $urandom_range(0, 3);
                else
                    bst = $urandom_range(1, 250);
                send_item(srtf_pkg::CMD_LOAD, arr, bst);
            end else begin
                send_item(srtf_pkg::CMD_TICK, $urandom, $urandom);
            end
        end
        gaps_on = 1'b1;
    endtask

    // fill the table with late and random arrivals, refuse further loads, keep ticking
    task automatic test_full_table();
        while (loaded_cnt < srtf_pkg::MAX_PROC)
            send_item(srtf_pkg::CMD_LOAD,
                      ($urandom_range(0, 1) == 0) ? 16'hFFFF : $urandom_range(0, 16'hFFFF),
                      $urandom_range(1, 3));
        send_item(srtf_pkg::CMD_LOAD, 16'hFFFF, 16'hFFFF);
        send_item(srtf_pkg::CMD_LOAD, $urandom, $urandom);
        send_item(srtf_pkg::CMD_LOAD, 0, 0);
        repeat (FINAL_TICKS) send_item(srtf_pkg::CMD_TICK, $urandom, $urandom);
    endtask

    // main sequence
    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_empty_table();
        test_directed_priorities();
        test_random_mix();
        test_full_table();
        start <= 1'b0;

        // drain outstanding results, then give the block time to settle
        drain_wait = 0;
        while (pending_results.size() != 0 && drain_wait < 1000) begin
            @(posedge i_clk);
            drain_wait++;
        end
        repeat (40) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d result transactions never arrived", pending_results.size());
            error_cnt++;
        end

        $display("covered %0d loads taken and %0d refused, %0d scheduled ticks",
                 seen_loads, seen_full, seen_runs);
        $display("with %0d completions, %0d idle ticks, final time %0d",
                 seen_done, seen_idle, sched_now);
        if (error_cnt == 0) begin
            $display("shortest_remaining_time_scheduler verification clean");
        end else begin
            $display("shortest_remaining_time_scheduler verification failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #40_000_000;
        $display("shortest_remaining_time_scheduler verification failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/srtf_pkg.sv
rtl/srtf_ram.sv
rtl/srtf_sel.sv
rtl/shortest_remaining_time_scheduler.sv
rtl/srtf_checker.sv
verif/tb_top.sv
